[rtl/timer_counter_pwm_postscaler_defines.svh]
// Assertion macros shared by the timer/counter RTL
`ifndef TIMER_COUNTER_PWM_POSTSCALER_DEFINES_SVH
`define TIMER_COUNTER_PWM_POSTSCALER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcp_pkg.sv]
// Types, register indices and constants of the timer/counter
`default_nettype none

package tcp_pkg;

    // Fixed widths of the register file and prescaler
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned PRESCALE_BITS = 10;
    localparam int unsigned LIMIT_BITS    = 16;
    localparam int unsigned VALUE_BITS    = 8;

    // Waveform modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CTC    = 2'd1,
        MODE_FAST   = 2'd2,
        MODE_PHASE  = 2'd3
    } t_mode;

    // Register indices
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE          = 3'd0,
        REG_INVERT        = 3'd1,
        REG_CLOCK_SELECT  = 3'd2,
        REG_COMPARE       = 3'd3,
        REG_OVF_LIMIT     = 3'd4,
        REG_PRELOAD       = 3'd5,
        REG_MATCH_LIMIT   = 3'd6
    } t_cfg_idx;

    // Clock select codes
    typedef enum logic [2:0] {
        CS_STOP    = 3'd0,
        CS_DIV1    = 3'd1,
        CS_DIV8    = 3'd2,
        CS_DIV64   = 3'd3,
        CS_DIV256  = 3'd4,
        CS_DIV1024 = 3'd5
    } t_clock_sel;

    typedef logic [PRESCALE_BITS:0] t_divisor;

    // Divisor for a clock select code; zero stops the timer
    function automatic t_divisor prescale_divisor(input logic [2:0] cs);
        t_divisor d;
        unique case (cs)
            CS_DIV1:    d = t_divisor'(1);
            CS_DIV8:    d = t_divisor'(8);
            CS_DIV64:   d = t_divisor'(64);
            CS_DIV256:  d = t_divisor'(256);
            CS_DIV1024: d = t_divisor'(1024);
            default:    d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/tcp_postscaler.sv]
// Event postscaler: counts events up to a limit and fires once per limit
`default_nettype none

module tcp_postscaler #(
    parameter int unsigned TALLY_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_event,
    input  wire [tcp_pkg::LIMIT_BITS-1:0]  i_limit,
    output logic                           o_fire
);
    import tcp_pkg::*;

    // Compare width covers both the tally span and the limit
    localparam int unsigned CmpBits =
        ((TALLY_BITS > LIMIT_BITS) ? TALLY_BITS : LIMIT_BITS) + 1;

    logic [TALLY_BITS-1:0] r_tally;
    logic [TALLY_BITS-1:0] n_tally;
    logic [CmpBits-1:0]    w_span;
    logic [CmpBits-1:0]    w_limit;
    logic [CmpBits-1:0]    w_eff;
    logic [CmpBits-1:0]    w_next;

    // Limit of zero, or beyond the tally span, means a full span
    always_comb begin
        w_span  = CmpBits'(1) << TALLY_BITS;
        w_limit = CmpBits'(i_limit);
        w_eff   = ((i_limit == '0) || (w_limit > w_span)) ? w_span : w_limit;
        w_next  = CmpBits'(r_tally) + CmpBits'(1);
        o_fire  = i_event && (w_next >= w_eff);
        if (!i_event) begin
            n_tally = r_tally;
        end else if (o_fire) begin
            n_tally = '0;
        end else begin
            n_tally = w_next[TALLY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else begin
            r_tally <= n_tally;
        end
    end

endmodule

`default_nettype wire

[rtl/timer_counter_pwm_postscaler.sv]
// Timer/counter with prescaler, four waveform modes and two postscalers
//
// Input channel (i_in_valid / o_in_ready / i_tick): one request per system
// tick; i_tick = 0 lets no time pass. Output channel (o_out_valid /
// i_out_ready) returns one result per request: counter value, pin level,
// overflow and match flags and the two postscaler actions.
// A request is held in the input register; the timer step is worked out
// from it and the result is registered in the result register. One request
// per cycle is sustained while the receiver takes results: the input
// register refills in the cycle its request moves on.
// If the receiver stalls, the result register holds and the input register
// keeps at most one more request; o_in_ready drops only when both are full.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, one register
// per cycle; the user writes them only while no request is outstanding, as the block itself does not enforce it.
// Synchronous reset (i_rst_n low) empties both registers, stops the clock
// select, zeroes counter, prescaler, tallies and pin, and sets the overflow
// limit to one.
`default_nettype none
`include "timer_counter_pwm_postscaler_defines.svh"

module timer_counter_pwm_postscaler #(
    parameter int unsigned COUNTER_BITS = 8,
    parameter int unsigned TALLY_BITS   = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration writes
    input  wire                                i_cfg_we,
    input  wire [tcp_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire [tcp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // tick requests
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_tick,
    // results
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [COUNTER_BITS-1:0]            o_count,
    output logic                               o_wave_out,
    output logic                               o_overflow_flag,
    output logic                               o_match_flag,
    output logic                               o_overflow_action,
    output logic                               o_match_action
);
    import tcp_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CntMax = '1;

    // configuration registers
    t_mode                  r_mode;
    logic                   r_invert;
    logic [2:0]             r_clock_sel;
    logic [VALUE_BITS-1:0]  r_compare;
    logic [LIMIT_BITS-1:0]  r_ovf_limit;
    logic [VALUE_BITS-1:0]  r_preload;
    logic [LIMIT_BITS-1:0]  r_match_limit;

    // input register
    logic                   r_in_valid;
    logic                   r_tick;

    // timer state
    logic [PRESCALE_BITS-1:0] r_prescale;
    logic [PRESCALE_BITS-1:0] n_prescale;
    logic [COUNTER_BITS-1:0]  r_timer;
    logic [COUNTER_BITS-1:0]  n_timer;
    logic                     r_down;
    logic                     n_down;
    logic                     r_wave;
    logic                     n_wave;

    // result register
    logic                     r_out_valid;
    logic [COUNTER_BITS-1:0]  r_count;
    logic                     r_wave_out;
    logic                     r_ovf;
    logic                     r_mat;
    logic                     r_ovf_act;
    logic                     r_mat_act;

    // step logic
    logic                               w_advance;
    t_divisor                           w_div;
    t_divisor                           w_pc;
    logic                               w_running;
    logic                               w_timer_clk;
    logic [COUNTER_BITS+VALUE_BITS-1:0] w_cmp_ext;
    logic [COUNTER_BITS+VALUE_BITS-1:0] w_pre_ext;
    logic [COUNTER_BITS-1:0]            w_cmp;
    logic [COUNTER_BITS-1:0]            w_pre;
    logic [COUNTER_BITS-1:0]            w_step;
    logic                               w_ovf;
    logic                               w_mat;
    logic                               w_ovf_act;
    logic                               w_mat_act;
    logic                               w_wave_out;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NORMAL;
            r_invert      <= 1'b0;
            r_clock_sel   <= CS_STOP;
            r_compare     <= '0;
            r_ovf_limit   <= LIMIT_BITS'(1);
            r_preload     <= '0;
            r_match_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:         r_mode        <= t_mode'(i_cfg_data[1:0]);
                REG_INVERT:       r_invert      <= i_cfg_data[0];
                REG_CLOCK_SELECT: r_clock_sel   <= i_cfg_data[2:0];
                REG_COMPARE:      r_compare     <= i_cfg_data[VALUE_BITS-1:0];
                REG_OVF_LIMIT:    r_ovf_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                REG_PRELOAD:      r_preload     <= i_cfg_data[VALUE_BITS-1:0];
                REG_MATCH_LIMIT:  r_match_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the request moves on whenever the result slot frees up
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_tick <= i_tick;
        end
    end

    // Prescaler: a timer clock once the count reaches the divisor
    always_comb begin
        w_div       = prescale_divisor(r_clock_sel);
        w_pc        = t_divisor'(r_prescale) + t_divisor'(1);
        w_running   = r_tick && (w_div != '0);
        w_timer_clk = w_running && (w_pc >= w_div);
        if (!w_running) begin
            n_prescale = r_prescale;
        end else if (w_timer_clk) begin
            n_prescale = '0;
        end else begin
            n_prescale = w_pc[PRESCALE_BITS-1:0];
        end
    end

    // Compare and preload values fitted to the counter width
    always_comb begin
        w_cmp_ext = (COUNTER_BITS+VALUE_BITS)'(r_compare);
        w_pre_ext = (COUNTER_BITS+VALUE_BITS)'(r_preload);
        w_cmp     = w_cmp_ext[COUNTER_BITS-1:0];
        w_pre     = w_pre_ext[COUNTER_BITS-1:0];
    end

    // Counter step, direction and pin level for one timer clock
    always_comb begin
        w_step = r_timer;
        n_down = r_down;
        n_wave = r_wave;
        w_ovf  = 1'b0;
        w_mat  = 1'b0;
        if (w_timer_clk) begin
            if (r_mode == MODE_PHASE) begin
                // up/down: turn at the top and at bottom
                if (!r_down) begin
                    if (r_timer == CntMax) begin
                        n_down = 1'b1;
                        w_step = CntMax - COUNTER_BITS'(1);
                    end else begin
                        w_step = r_timer + COUNTER_BITS'(1);
                    end
                end else begin
                    if (r_timer == '0) begin
                        n_down = 1'b0;
                        w_step = COUNTER_BITS'(1);
                    end else begin
                        w_step = r_timer - COUNTER_BITS'(1);
                    end
                end
                w_ovf = (w_step == '0) && n_down;
                w_mat = (w_step == w_cmp);
                if (w_mat) begin
                    n_wave = n_down;
                end
            end else begin
                // up counting, cleared after a match in CTC
                if ((r_mode == MODE_CTC) && (r_timer == w_cmp)) begin
                    w_step = '0;
                end else begin
                    w_step = r_timer + COUNTER_BITS'(1);
                end
                w_ovf = (r_timer == CntMax) && (w_step == '0);
                w_mat = (w_step == w_cmp);
                if (r_mode == MODE_FAST) begin
                    if (w_step == '0) begin
                        n_wave = 1'b1;
                    end else if (w_mat) begin
                        n_wave = 1'b0;
                    end
                end
            end
        end
    end

    // Postscalers
    tcp_postscaler #(
        .TALLY_BITS (TALLY_BITS)
    ) u_ovf_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_event (w_ovf && w_advance),
        .i_limit (r_ovf_limit),
        .o_fire  (w_ovf_act)
    );

    tcp_postscaler #(
        .TALLY_BITS (TALLY_BITS)
    ) u_mat_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_event (w_mat && w_advance),
        .i_limit (r_match_limit),
        .o_fire  (w_mat_act)
    );

    // Overflow action reloads the counter; pin driven only in PWM modes
    always_comb begin
        n_timer    = w_ovf_act ? w_pre : w_step;
        w_wave_out = r_mode[1] ? (n_wave ^ r_invert) : 1'b0;
    end

    // Timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_timer    <= '0;
            r_down     <= 1'b0;
            r_wave     <= 1'b0;
        end else if (w_advance) begin
            r_prescale <= n_prescale;
            r_timer    <= n_timer;
            r_down     <= n_down;
            r_wave     <= n_wave;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_count    <= n_timer;
            r_wave_out <= w_wave_out;
            r_ovf      <= w_ovf;
            r_mat      <= w_mat;
            r_ovf_act  <= w_ovf_act;
            r_mat_act  <= w_mat_act;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_count           = r_count;
    assign o_wave_out        = r_wave_out;
    assign o_overflow_flag   = r_ovf;
    assign o_match_flag      = r_mat;
    assign o_overflow_action = r_ovf_act;
    assign o_match_action    = r_mat_act;

    // Checks
    `TCP_ASSERT_NOW(a_ovf_act_flag, o_out_valid && o_overflow_action, o_overflow_flag, "overflow action without overflow")
    `TCP_ASSERT_NOW(a_mat_act_flag, o_out_valid && o_match_action, o_match_flag, "match action without match")
    `TCP_ASSERT_NEXT(a_slot_fills, r_in_valid && !r_out_valid, r_out_valid, "request did not reach result slot")

endmodule

`default_nettype wire
